### rtl/core/nmea_checksum_validator_top_defines.svh
// ----------------------------------------------------------------------------
// NMEA checksum validator assertion macros
// Shorthand for the concurrent checks of the validator, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NMEA_CHECKSUM_VALIDATOR_TOP_DEFINES_SVH
`define NMEA_CHECKSUM_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define NMCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NMCV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/nmcv_pkg.sv
// ----------------------------------------------------------------------------
// NMEA checksum validator package
// Payload types, phase and reason codes, and the hex digit helper.
// ----------------------------------------------------------------------------
package nmcv_pkg;

	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] LIMIT_RESET = 8'd75;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BODY = 3'd1,
		PH_HIGH = 3'd2,
		PH_LOW  = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		WHY_OK       = 3'd0,
		WHY_NODOLLAR = 3'd1,
		WHY_TOOLONG  = 3'd2,
		WHY_NOSEP    = 3'd3,
		WHY_MISMATCH = 3'd4
	} reason_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       sentence_start;
	} char_t;

	typedef struct packed {
		logic       sentence_ok;
		logic [2:0] fail_reason;
		logic [7:0] computed_sum;
	} verdict_t;

	typedef struct packed {
		logic     valid;
		verdict_t item;
	} result_t;

	// Uppercase ASCII hex digit of a nibble.
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'h0, nib};
		end else begin
			return 8'h37 + {4'h0, nib};
		end
	endfunction

endpackage

### rtl/core/nmcv_in_reg.sv
// ----------------------------------------------------------------------------
// NMEA checksum validator input register
// Captures one character transaction and holds it while the pipe is stalled.
// ----------------------------------------------------------------------------
module nmcv_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	input  nmcv_pkg::char_t char_item,
	input  logic            advance,
	output logic            char_stall,
	output logic            valid_s1,
	output nmcv_pkg::char_t item_s1
);

	logic load;

	assign load       = advance || !valid_s1;
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && char_valid) begin
			item_s1 <= char_item;
		end
	end

endmodule

### rtl/core/nmcv_checker.sv
// ----------------------------------------------------------------------------
// NMEA checksum validator sentence checker
// Phase machine, running XOR, character index and the length limit register.
// ----------------------------------------------------------------------------
module nmcv_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              step,
	input  nmcv_pkg::char_t   item_s1,
	output nmcv_pkg::result_t result
);

	nmcv_pkg::phase_t phase_q, phase_d;
	logic [7:0]       xor_q, xor_d;
	logic [7:0]       index_q, index_d;
	logic             high_ok_q, high_ok_d;
	logic [7:0]       limit_q;
	logic [7:0]       ch;
	logic             start;

	assign ch    = item_s1.char_in;
	assign start = item_s1.sentence_start;

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		xor_d     = xor_q;
		index_d   = index_q;
		high_ok_d = high_ok_q;
		if (start) begin
			xor_d     = 8'h00;
			high_ok_d = 1'b0;
			if (ch != nmcv_pkg::CH_DOLLAR) begin
				phase_d = nmcv_pkg::PH_DONE;
				index_d = 8'd0;
			end else begin
				phase_d = nmcv_pkg::PH_BODY;
				index_d = 8'd1;
			end
		end else begin
			unique case (phase_q)
				nmcv_pkg::PH_BODY: begin
					priority if (index_q >= limit_q) begin
						phase_d = nmcv_pkg::PH_DONE;
					end else if (ch == nmcv_pkg::CH_NUL) begin
						phase_d = nmcv_pkg::PH_DONE;
					end else if (ch == nmcv_pkg::CH_STAR) begin
						phase_d = nmcv_pkg::PH_HIGH;
					end else begin
						xor_d   = xor_q ^ ch;
						index_d = index_q + 8'd1;
					end
				end
				nmcv_pkg::PH_HIGH: begin
					high_ok_d = (ch == nmcv_pkg::hex_digit(xor_q[7:4]));
					phase_d   = nmcv_pkg::PH_LOW;
				end
				nmcv_pkg::PH_LOW: begin
					phase_d = nmcv_pkg::PH_DONE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Verdict output.
	always_comb begin
		nmcv_pkg::reason_t why;
		logic              fire;
		why  = nmcv_pkg::WHY_OK;
		fire = 1'b0;
		if (start) begin
			if (ch != nmcv_pkg::CH_DOLLAR) begin
				fire = 1'b1;
				why  = nmcv_pkg::WHY_NODOLLAR;
			end
		end else begin
			unique case (phase_q)
				nmcv_pkg::PH_BODY: begin
					priority if (index_q >= limit_q) begin
						fire = 1'b1;
						why  = nmcv_pkg::WHY_TOOLONG;
					end else if (ch == nmcv_pkg::CH_NUL) begin
						fire = 1'b1;
						why  = nmcv_pkg::WHY_NOSEP;
					end else begin
						fire = 1'b0;
					end
				end
				nmcv_pkg::PH_LOW: begin
					fire = 1'b1;
					if (high_ok_q && ch == nmcv_pkg::hex_digit(xor_q[3:0])) begin
						why = nmcv_pkg::WHY_OK;
					end else begin
						why = nmcv_pkg::WHY_MISMATCH;
					end
				end
				default: begin
					fire = 1'b0;
				end
			endcase
		end
		result.valid             = step && fire;
		result.item.sentence_ok  = (why == nmcv_pkg::WHY_OK);
		result.item.fail_reason  = why;
		// Missing dollar clears the sum before the verdict.
		result.item.computed_sum = start ? 8'h00 : xor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= nmcv_pkg::PH_IDLE;
			xor_q     <= 8'h00;
			index_q   <= 8'd0;
			high_ok_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			xor_q     <= xor_d;
			index_q   <= index_d;
			high_ok_q <= high_ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= nmcv_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

endmodule

### rtl/core/nmcv_out_reg.sv
// ----------------------------------------------------------------------------
// NMEA checksum validator output register
// Holds one verdict transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module nmcv_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  nmcv_pkg::result_t  result,
	output logic               verdict_valid,
	output nmcv_pkg::verdict_t verdict_item
);

	logic               valid_q;
	nmcv_pkg::verdict_t item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			item_q <= result.item;
		end
	end

	assign verdict_valid = valid_q;
	assign verdict_item  = item_q;

endmodule

### rtl/core/nmea_checksum_validator_top.sv
// ----------------------------------------------------------------------------
// NMEA checksum validator top level
// Path: the input register takes the character, the verdict register its verdict.
// Throughput: one character per cycle; the input register and the verdict
// register stall together only when a verdict waits and is not taken.
// Reset: pipe empty, phase idle, sum and index zero, length limit 75.
// ----------------------------------------------------------------------------
`include "nmea_checksum_validator_top_defines.svh"

module nmea_checksum_validator_top (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: length limit register
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	// Character channel
	input  logic               char_valid,
	output logic               char_stall,
	input  nmcv_pkg::char_t    char_item,
	// Verdict channel
	output logic               verdict_valid,
	input  logic               verdict_stall,
	output nmcv_pkg::verdict_t verdict_item
);

	logic              advance;
	logic              valid_s1;
	logic              step;
	nmcv_pkg::char_t   item_s1;
	nmcv_pkg::result_t result;

	// The whole pipe moves unless a verdict sits in the output register and
	// the consumer stalls it. A character held in stage one is processed only
	// when it moves, so the sentence state never sees a character twice.
	assign advance = !verdict_valid || !verdict_stall;
	assign step    = valid_s1 && advance;

	// Stage one: capture the incoming character transaction.
	nmcv_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_item  (char_item),
		.advance    (advance),
		.char_stall (char_stall),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Sentence state and verdict decision: XOR, compare and phase update on
	// the character in stage one; the limit register lives here as well.
	nmcv_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item_s1   (item_s1),
		.result    (result)
	);

	// Stage two: hold the verdict transaction for the consumer.
	nmcv_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.result        (result),
		.verdict_valid (verdict_valid),
		.verdict_item  (verdict_item)
	);

	// Only a held character may push back on the producer.
	`NMCV_ASSERT_IMP(a_stall_needs_item, char_stall, valid_s1, "stall with empty stage one")
	// A character that cannot move keeps its slot and its value.
	`NMCV_ASSERT_NXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(item_s1), "stage one lost a held character")
	// The ok flag agrees with the reason code.
	`NMCV_ASSERT_IMP(a_ok_matches_reason, verdict_valid, verdict_item.sentence_ok == (verdict_item.fail_reason == nmcv_pkg::WHY_OK), "ok flag disagrees with reason")
	// A sentence without a dollar has no body to sum.
	`NMCV_ASSERT_IMP(a_nodollar_zero_sum, verdict_valid && verdict_item.fail_reason == nmcv_pkg::WHY_NODOLLAR, verdict_item.computed_sum == 8'h00, "missing dollar with nonzero sum")

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// NMEA checksum validator testbench
// Streams sentence characters into the validator under random gaps and
// verdict stalls, predicts every verdict from its own copy of the sentence
// state, and checks each verdict field by field in arrival order. The length
// limit register is swept between phases, including the smallest values.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PER_PHASE = 76;

	// Clock, reset and block inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic char_valid = 1'b0;
	logic char_stall;
	nmcv_pkg::char_t char_item = '0;
	logic verdict_valid;
	logic verdict_stall = 1'b0;
	nmcv_pkg::verdict_t verdict_item;

	// Characters waiting to be driven, verdicts waiting to arrive
	nmcv_pkg::char_t pending_chars[$];
	nmcv_pkg::verdict_t verdicts_due[$];

	// Predicted sentence state and the limit as last written
	nmcv_pkg::phase_t sent_phase = nmcv_pkg::PH_IDLE;
	logic [7:0] sent_sum = '0;
	logic [7:0] sent_index = '0;
	logic sent_high_ok = 1'b0;
	logic [7:0] limit_q = nmcv_pkg::LIMIT_RESET;

	// Bookkeeping
	int cycles = 0;
	int err_count = 0;
	int n_chars = 0;
	int n_verdicts = 0;
	int n_passed = 0;
	int n_limits = 0;
	int gap_left = 0;
	int hold_left = 0;
	bit calm = 1'b0;

	nmea_checksum_validator_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_item    (char_item),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_item (verdict_item)
	);

	always #2 clk = ~clk;

	// Hard stop in case a transaction never completes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts still due",
				cycles, verdicts_due.size());
			$display("tb_top: errors");
			$finish;
		end
	end

	// Idle length per transaction; calm stretches run back to back
	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// Uppercase ASCII hex digit, written out independently of the package
	function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
		logic [7:0] d;
		if (nib <= 4'd9) begin
			d = 8'h30 | {4'h0, nib};
		end else begin
			d = 8'h41 + {4'h0, nib} - 8'd10;
		end
		return d;
	endfunction

	// Advance the predicted sentence state by one accepted character and
	// queue a verdict when that character decides the sentence.
	function automatic void track_char(input nmcv_pkg::char_t ch);
		logic decided;
		nmcv_pkg::reason_t why;
		nmcv_pkg::verdict_t v;
		decided = 1'b0;
		why = nmcv_pkg::WHY_OK;
		if (ch.sentence_start) begin
			// A start always opens a fresh sentence, abandoning any open one
			sent_sum = '0;
			sent_index = '0;
			sent_high_ok = 1'b0;
			if (ch.char_in != nmcv_pkg::CH_DOLLAR) begin
				decided = 1'b1;
				why = nmcv_pkg::WHY_NODOLLAR;
			end else begin
				sent_phase = nmcv_pkg::PH_BODY;
				sent_index = 8'd1;
			end
		end else begin
			case (sent_phase)
				nmcv_pkg::PH_BODY: begin
					// The length check wins over whatever the character is
					if (sent_index >= limit_q) begin
						decided = 1'b1;
						why = nmcv_pkg::WHY_TOOLONG;
					end else if (ch.char_in == nmcv_pkg::CH_NUL) begin
						decided = 1'b1;
						why = nmcv_pkg::WHY_NOSEP;
					end else if (ch.char_in == nmcv_pkg::CH_STAR) begin
						sent_phase = nmcv_pkg::PH_HIGH;
					end else begin
						sent_sum = sent_sum ^ ch.char_in;
						sent_index = sent_index + 8'd1;
					end
				end
				nmcv_pkg::PH_HIGH: begin
					sent_high_ok = (ch.char_in == ascii_hex(sent_sum[7:4]));
					sent_phase = nmcv_pkg::PH_LOW;
				end
				nmcv_pkg::PH_LOW: begin
					decided = 1'b1;
					why = (sent_high_ok && ch.char_in == ascii_hex(sent_sum[3:0]))
						? nmcv_pkg::WHY_OK : nmcv_pkg::WHY_MISMATCH;
				end
				default: begin
					// Idle or finished: drop the character
				end
			endcase
		end
		if (decided) begin
			v.sentence_ok = (why == nmcv_pkg::WHY_OK);
			v.fail_reason = why;
			v.computed_sum = sent_sum;
			verdicts_due.push_back(v);
			sent_phase = nmcv_pkg::PH_DONE;
		end
	endfunction

	function automatic void check_verdict(input nmcv_pkg::verdict_t got);
		nmcv_pkg::verdict_t want;
		if (verdicts_due.size() == 0) begin
			$error("verdict with none due: ok %0d reason %0d sum %02h",
				got.sentence_ok, got.fail_reason, got.computed_sum);
			err_count++;
			return;
		end
		want = verdicts_due.pop_front();
		n_verdicts++;
		if (want.sentence_ok) n_passed++;
		if (got.sentence_ok !== want.sentence_ok) begin
			$error("sentence_ok: expected %0d, got %0d", want.sentence_ok, got.sentence_ok);
			err_count++;
		end
		if (got.fail_reason !== want.fail_reason) begin
			$error("fail_reason: expected %0d, got %0d", want.fail_reason, got.fail_reason);
			err_count++;
		end
		if (got.computed_sum !== want.computed_sum) begin
			$error("computed_sum: expected %02h, got %02h",
				want.computed_sum, got.computed_sum);
			err_count++;
		end
	endfunction

	// Driver: whenever the slot is free, either idle out the drawn gap or
	// present the next pending character. A stalled character is held as is.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!char_valid || !char_stall) begin
				if (char_valid) begin
					// Transaction completed at this edge
					track_char(char_item);
					n_chars++;
				end
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					char_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					char_item <= pending_chars.pop_front();
					char_valid <= 1'b1;
					gap_left <= draw_wait();
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: take each verdict, then stall for a freshly drawn stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (verdict_valid && !verdict_stall) begin
				check_verdict(verdict_item);
				hold_left = draw_wait();
			end
			if (hold_left > 0) begin
				verdict_stall <= 1'b1;
				hold_left--;
			end else begin
				verdict_stall <= 1'b0;
			end
		end
	end

	function automatic void put_char(input logic [7:0] c, input logic st);
		nmcv_pkg::char_t it;
		it.char_in = c;
		it.sentence_start = st;
		pending_chars.push_back(it);
	endfunction

	// First character carries the start flag, the rest follow it
	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			put_char(s[i], i == 0);
		end
	endfunction

	// Wait until every character is in and every verdict has come out, then
	// let the pipe settle, since the last character may have decided nothing.
	task automatic drain();
		do @(negedge clk);
		while (pending_chars.size() != 0 || char_valid || verdicts_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= 8'($urandom);
		limit_q = value;
		n_limits++;
	endtask

	// One random sentence, mostly well formed, the rest broken in one way.
	// Stray bytes, trailing junk and line endings are left out of the count.
	task automatic add_random_sentence(output int used);
		logic [7:0] body[$];
		logic [7:0] sum;
		logic [7:0] c;
		logic [7:0] hi;
		logic [7:0] lo;
		string digits;
		int kind;
		int len;
		int span;
		body = {};
		sum = '0;
		used = 0;
		kind = $urandom_range(0, 99);
		span = (limit_q > 8'd1) ? int'(limit_q) - 1 : 0;
		if (kind >= 95) begin
			// Stray bytes with no start flag
			repeat ($urandom_range(1, 4)) put_char(8'($urandom), 1'b0);
			return;
		end
		if (kind >= 80 && kind < 85) begin
			// Sentence that does not open with a dollar, then trailing junk
			do c = 8'($urandom); while (c == nmcv_pkg::CH_DOLLAR);
			put_char(c, 1'b1);
			used = 1;
			repeat ($urandom_range(0, 3)) put_char(8'($urandom), 1'b0);
			return;
		end
		// Overlong sentences at large limits are costly; keep them rare
		if (kind >= 90 && limit_q > 8'd64 && $urandom_range(0, 3) != 0) kind = 0;
		if (kind >= 90) begin
			len = int'(limit_q) + $urandom_range(0, 2);
		end else if ($urandom_range(0, 7) == 0) begin
			len = $urandom_range(0, span);
		end else begin
			len = $urandom_range(0, (span < 12) ? span : 12);
		end
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 1)) begin
				c = 8'($urandom_range(8'h20, 8'h7E));
			end else begin
				c = 8'($urandom_range(1, 255));
			end
			if (c == nmcv_pkg::CH_STAR) c = 8'h2B;
			body.push_back(c);
			sum = sum ^ c;
		end
		put_char(nmcv_pkg::CH_DOLLAR, 1'b1);
		foreach (body[k]) put_char(body[k], 1'b0);
		used = 1 + len;
		if (kind >= 72 && kind < 76) begin
			// Body ends in a NUL before any separator
			put_char(nmcv_pkg::CH_NUL, 1'b0);
			used++;
			repeat ($urandom_range(0, 2)) put_char(8'($urandom), 1'b0);
			return;
		end
		if (kind >= 85 && kind < 90) begin
			// Cut short; the next start abandons it
			return;
		end
		digits = (kind >= 68 && kind < 72) ? $sformatf("%02x", sum) : $sformatf("%02X", sum);
		hi = digits[0];
		lo = digits[1];
		if (kind >= 60 && kind < 68) begin
			if ($urandom_range(0, 1)) begin
				do c = 8'($urandom); while (c == hi);
				hi = c;
			end else begin
				do c = 8'($urandom); while (c == lo);
				lo = c;
			end
		end else if (kind >= 76 && kind < 80) begin
			if ($urandom_range(0, 1)) hi = nmcv_pkg::CH_NUL;
			else lo = nmcv_pkg::CH_NUL;
		end
		put_char(nmcv_pkg::CH_STAR, 1'b0);
		put_char(hi, 1'b0);
		put_char(lo, 1'b0);
		used += 3;
		// Line ending after the verdict, dropped by the block
		if ($urandom_range(0, 1)) begin
			put_char(8'h0D, 1'b0);
			put_char(8'h0A, 1'b0);
		end
	endtask

	task automatic run_random(input int n);
		int count;
		int used;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 7) == 0) calm = ~calm;
			add_random_sentence(used);
			count += used;
			// Feed the driver gradually so calm stretches land in time
			while (pending_chars.size() > 8) @(negedge clk);
		end
	endtask

	initial begin
		// Hold reset, release it between edges
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sentences at the reset limit
		add_text("X");                   // no leading dollar
		put_char(8'h51, 1'b0);           // ignored after the verdict
		add_text("$A");
		put_char(nmcv_pkg::CH_NUL, 1'b0);          // NUL before the separator
		add_text("$A*4");
		put_char(nmcv_pkg::CH_NUL, 1'b0);          // NUL in the checksum digits
		put_char(nmcv_pkg::CH_DOLLAR, 1'b1);       // bytes above 127, FF ^ 80 = 7F
		put_char(8'hFF, 1'b0);
		put_char(8'h80, 1'b0);
		add_text("*7F");
		put_char(8'h00, 1'b0);           // ignored, all-zero byte
		add_text("$AB");                 // abandoned by the next start
		add_text("$*00");                // empty body

		// Shortest legal limit, then the tiny limits below it
		write_limit(8'd2);
		add_text("$ABC");
		write_limit(8'd1);
		add_text("$A");
		write_limit(8'd0);
		add_text("$*00");

		// Random phases across the limit range
		write_limit(nmcv_pkg::LIMIT_RESET);
		run_random(RANDOM_PER_PHASE);
		write_limit(8'd255);
		run_random(RANDOM_PER_PHASE);
		write_limit(8'd2);
		run_random(RANDOM_PER_PHASE);
		write_limit(8'($urandom_range(3, 40)));
		run_random(RANDOM_PER_PHASE);
		write_limit(8'd0);
		run_random(RANDOM_PER_PHASE / 2);
		write_limit(8'($urandom_range(2, 255)));
		run_random(RANDOM_PER_PHASE + RANDOM_PER_PHASE / 2);

		calm = 1'b0;
		drain();
		repeat (4) @(posedge clk);

		$display("summary: %0d characters sent, %0d verdicts checked, %0d of them passing",
			n_chars, n_verdicts, n_passed);
		$display("summary: %0d length limit settings, %0d mismatches", n_limits, err_count);
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
